@@ src/two_level_timer_wheel_unit_macros.svh @@
// assertion macros for the two-level timer wheel
// used by the top level; no other dependencies
`ifndef TWO_LEVEL_TIMER_WHEEL_UNIT_MACROS_SVH
`define TWO_LEVEL_TIMER_WHEEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TW_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TW_ASSERT(label, clk, rst_n, prop)
`define TW_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ src/tlw_pkg.sv @@
// shared types and constants of the two-level timer wheel
// no dependencies
package tlw_pkg;
    localparam int INNER_SLOTS_DEF = 128;
    localparam int OUTER_SLOTS_DEF = 128;
    localparam int TIMERS_DEF = 32;

    localparam int ACT_W = 2;
    localparam int ID_W = 5;
    localparam int LOAD_W = 15;
    localparam int KIND_W = 2;

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_result;
endpackage

@@ src/tlw_ram.sv @@
// generic single-port-write, single-read ram with registered read data
// no dependencies
module tlw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/tlw_place.sv @@
// placement arithmetic: inner or outer slot for a load from the cursors
// depends on tlw_pkg
module tlw_place #(
    parameter int INNER_SLOTS = tlw_pkg::INNER_SLOTS_DEF,
    parameter int OUTER_SLOTS = tlw_pkg::OUTER_SLOTS_DEF,
    localparam int IW = $clog2(INNER_SLOTS),
    localparam int OW = $clog2(OUTER_SLOTS),
    localparam int SW = (IW > OW) ? IW : OW
) (
    input  logic [tlw_pkg::LOAD_W-1:0] i_load,
    input  logic [IW-1:0]              i_icur,
    input  logic [OW-1:0]              i_ocur,
    output logic                       o_ok,
    output logic                       o_outer,
    output logic [SW-1:0]              o_slot,
    output logic [IW-1:0]              o_target
);
    localparam int SUMW = tlw_pkg::LOAD_W + 1;
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] q;
    logic [OW:0]     oslot;

    always_comb begin
        sum = SUMW'(i_load) + SUMW'(i_icur);
        q = sum >> IW;
        oslot = (OW+1)'(i_ocur) + (OW+1)'(q);
        o_target = sum[IW-1:0];
        o_outer = (SUMW'(i_load) >= SUMW'(INNER_SLOTS));
        o_ok = (i_load != '0) && (!o_outer || (q < SUMW'(OUTER_SLOTS)));
        if (o_outer) begin
            o_slot = SW'(oslot[OW-1:0]);
        end else begin
            o_slot = SW'(sum[IW-1:0]);
        end
    end
endmodule

@@ src/two_level_timer_wheel_unit.sv @@
// two-level timer wheel; timer records in one ram, armed bits in flops
// start/stop: result registered from the command state once the output is free
// tick: tick-done result after the scan; new transactions are taken only in idle;
// each timer entry gets a read and an evaluate state, an expiry waits while stalled
// expiries come out in ascending id order; result register parts the sides
// reset clears armed bits, both cursors and control, synchronous, active low
`include "two_level_timer_wheel_unit_macros.svh"
module two_level_timer_wheel_unit #(
    parameter int INNER_SLOTS = tlw_pkg::INNER_SLOTS_DEF,
    parameter int OUTER_SLOTS = tlw_pkg::OUTER_SLOTS_DEF,
    parameter int TIMERS = tlw_pkg::TIMERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tlw_pkg::ACT_W-1:0]   i_action,
    input  logic [tlw_pkg::ID_W-1:0]    i_timer_id,
    input  logic [tlw_pkg::LOAD_W-1:0]  i_load,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tlw_pkg::ID_W-1:0]    o_timer_id_res,
    output logic [tlw_pkg::KIND_W-1:0]  o_kind,
    output logic                        o_last
);
    localparam int IW = $clog2(INNER_SLOTS);
    localparam int OW = $clog2(OUTER_SLOTS);
    localparam int SW = (IW > OW) ? IW : OW;
    localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    // record: period, in_outer, slot, inner target
    localparam int RW = tlw_pkg::LOAD_W + 1 + SW + IW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMD  = 5'b00010,
        S_READ = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [TIMERS-1:0] r_armed, n_armed;
    logic [IW-1:0] r_icur, n_icur;
    logic [OW-1:0] r_ocur, n_ocur;
    logic [tlw_pkg::ACT_W-1:0] r_act;
    logic [tlw_pkg::ID_W-1:0] r_id;
    logic [tlw_pkg::LOAD_W-1:0] r_load;
    logic [CW-1:0] r_idx, n_idx;
    logic r_wrap, n_wrap;
    logic r_ovalid, n_ovalid;
    tlw_pkg::t_result r_res, n_res;

    logic ram_we;
    logic [TW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    logic [tlw_pkg::LOAD_W-1:0] pl_load;
    logic pl_ok, pl_outer;
    logic [SW-1:0] pl_slot;
    logic [IW-1:0] pl_target;

    logic [tlw_pkg::LOAD_W-1:0] rd_period;
    logic rd_outer;
    logic [SW-1:0] rd_slot;
    logic [IW-1:0] rd_target;
    logic [TW-1:0] cur_t;
    logic in_range, out_free;
    logic expire;
    logic rd_inner_outer;
    logic [SW-1:0] eff_slot;

    assign {rd_period, rd_outer, rd_slot, rd_target} = ram_rdata;
    assign cur_t = r_idx[TW-1:0];
    assign in_range = (32'(r_id) < TIMERS);
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    tlw_ram #(.WIDTH(RW), .DEPTH(1 << TW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    tlw_place #(.INNER_SLOTS(INNER_SLOTS), .OUTER_SLOTS(OUTER_SLOTS)) u_place (
        .i_load  (pl_load),
        .i_icur  (r_icur),
        .i_ocur  (r_ocur),
        .o_ok    (pl_ok),
        .o_outer (pl_outer),
        .o_slot  (pl_slot),
        .o_target(pl_target)
    );

    always_comb begin
        // cascade: a timer parked in the new outer slot drops into its inner target
        rd_inner_outer = rd_outer;
        eff_slot = rd_slot;
        if (r_wrap && rd_outer && rd_slot == SW'(r_ocur)) begin
            rd_inner_outer = 1'b0;
            eff_slot = SW'(rd_target);
        end
        expire = r_armed[cur_t] && !rd_inner_outer && eff_slot == SW'(r_icur);
    end

    always_comb begin
        n_state = r_state;
        n_armed = r_armed;
        n_icur = r_icur;
        n_ocur = r_ocur;
        n_idx = r_idx;
        n_wrap = r_wrap;
        n_ovalid = r_ovalid && i_stall;
        n_res = r_res;
        ram_we = 1'b0;
        ram_waddr = cur_t;
        ram_raddr = cur_t;
        ram_wdata = {rd_period, rd_inner_outer, eff_slot, rd_target};
        pl_load = r_load;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                if (out_free) begin
                    if (r_act == tlw_pkg::ACT_START) begin
                        n_ovalid = 1'b1;
                        n_res = '{id: r_id, kind: (in_range && pl_ok) ?
                            tlw_pkg::KIND_ACCEPTED : tlw_pkg::KIND_REJECTED, last: 1'b1};
                        if (in_range && pl_ok) begin
                            ram_we = 1'b1;
                            ram_waddr = TW'(r_id);
                            ram_wdata = {r_load, pl_outer, pl_slot, pl_target};
                            n_armed[TW'(r_id)] = 1'b1;
                        end
                        n_state = S_IDLE;
                    end else if (r_act == tlw_pkg::ACT_STOP) begin
                        n_ovalid = 1'b1;
                        n_res = '{id: r_id, kind: tlw_pkg::KIND_ACCEPTED, last: 1'b1};
                        if (in_range) begin
                            n_armed[TW'(r_id)] = 1'b0;
                        end
                        n_state = S_IDLE;
                    end else if (r_act == tlw_pkg::ACT_TICK) begin
                        n_icur = r_icur + IW'(1);
                        n_wrap = (r_icur == IW'(INNER_SLOTS - 1));
                        if (r_icur == IW'(INNER_SLOTS - 1)) begin
                            n_ocur = (r_ocur == OW'(OUTER_SLOTS - 1)) ? '0 : r_ocur + OW'(1);
                        end
                        n_idx = '0;
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                // address cur_t presented; data valid next cycle
                n_state = S_EVAL;
            end
            S_EVAL: begin
                pl_load = rd_period;
                if (!expire || out_free) begin
                    if (r_armed[cur_t]) begin
                        ram_we = 1'b1;
                    end
                    if (expire) begin
                        n_ovalid = 1'b1;
                        n_res = '{id: tlw_pkg::ID_W'(cur_t), kind: tlw_pkg::KIND_EXPIRED,
                            last: 1'b0};
                        if (pl_ok) begin
                            ram_wdata = {rd_period, pl_outer, pl_slot, pl_target};
                        end else begin
                            n_armed[cur_t] = 1'b0;
                        end
                    end
                    n_idx = r_idx + CW'(1);
                    if (r_idx == CW'(TIMERS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_res = '{id: '0, kind: tlw_pkg::KIND_TICK, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_armed <= '0;
            r_icur <= '0;
            r_ocur <= '0;
            r_idx <= '0;
            r_wrap <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_icur <= n_icur;
            r_ocur <= n_ocur;
            r_idx <= n_idx;
            r_wrap <= n_wrap;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE && i_valid) begin
            r_act <= i_action;
            r_id <= i_timer_id;
            r_load <= i_load;
        end
    end

    assign o_valid = r_ovalid;
    assign o_timer_id_res = r_res.id;
    assign o_kind = r_res.kind;
    assign o_last = r_res.last;

    `TW_ASSERT(a_onehot_state, i_clk, i_rst_n, $onehot(r_state))
    `TW_ASSERT(a_hold_result, i_clk, i_rst_n, (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_res)))
    `TW_ASSERT(a_idle_accept, i_clk, i_rst_n, (r_state == S_IDLE && i_valid) |=> (r_state == S_CMD))
    `TW_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_EVAL) |-> (r_idx < CW'(TIMERS)))
endmodule
